// ===== hw/rtl/hb64c_pkg.sv =====
package hb64c_pkg;

  localparam logic [7:0] PAD_CHAR     = 8'h3D;
  localparam logic [2:0] GROUP_DIGITS = 3'd6;
  localparam logic [2:0] PAD_TWO_POS  = 3'd2;
  localparam logic [2:0] PAD_ONE_POS  = 3'd4;
  localparam int         RES_DEPTH    = 4;

  typedef struct packed {
    logic [7:0] chr;
    logic       char_valid;
    logic       bad_hex;
    logic       run_last;
    logic       stream_done;
  } res_t;

  // Returns {is_hex, value}.
  function automatic logic [4:0] hex_digit_of(input logic [7:0] c);
    logic [4:0] r;
    r = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h61 + 8'd10)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h41 + 8'd10)};
    end
    return r;
  endfunction

  // Returns {is_symbol, value}.
  function automatic logic [6:0] b64_value(input logic [7:0] c);
    logic [6:0] r;
    r = '0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = {1'b1, 6'(c - 8'h41)};
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      r = {1'b1, 6'(c - 8'h61 + 8'd26)};
    end else if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 6'(c - 8'h30 + 8'd52)};
    end else if (c == 8'h2B) begin
      r = {1'b1, 6'd62};
    end else if (c == 8'h2F) begin
      r = {1'b1, 6'd63};
    end
    return r;
  endfunction

  function automatic logic [7:0] b64_char(input logic [5:0] s);
    logic [7:0] r;
    if (s < 6'd26) begin
      r = 8'h41 + {2'b00, s};
    end else if (s < 6'd52) begin
      r = 8'h61 + {2'b00, s} - 8'd26;
    end else if (s < 6'd62) begin
      r = 8'h30 + {2'b00, s} - 8'd52;
    end else if (s == 6'd62) begin
      r = 8'h2B;
    end else begin
      r = 8'h2F;
    end
    return r;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    logic [7:0] r;
    if (v < 4'd10) begin
      r = 8'h30 + {4'h0, v};
    end else begin
      r = 8'h61 + {4'h0, v} - 8'd10;
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/hex_base64_codec_unit.sv =====
// An accepted beat is registered, then its results are loaded into the result queue and shown.
// Throughput: one input beat per cycle while each beat yields at most one result and the
// output is not stalled; a beat that yields several results (up to four, at end of stream)
// holds the input until the result queue, which drains one beat per unstalled cycle, is empty.
// Reset (rst_n low, synchronous) selects encode mode and clears the bit buffer and counts.
module hex_base64_codec_unit
  import hb64c_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_decode_mode,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char,
  input  logic       in_end_of_stream,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_char,
  output logic       out_char_valid,
  output logic       out_bad_hex,
  output logic       out_run_last,
  output logic       out_stream_done
);

  logic        mode_r;
  logic [13:0] buf_r, buf_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [2:0]  gp_r, gp_nxt;

  logic        in_vld_r, in_vld_nxt;
  logic [7:0]  chr_r;
  logic        eos_r;

  res_t        q_r [RES_DEPTH];
  res_t        q_nxt [RES_DEPTH];
  logic [2:0]  q_cnt_r, q_cnt_nxt;

  res_t        lst [RES_DEPTH];
  logic [2:0]  n;
  logic [4:0]  hv;
  logic [6:0]  bv;
  logic [13:0] nb, nb2;
  logic [3:0]  nc, nc2;
  logic [5:0]  sx;
  logic [7:0]  byte_v;
  logic [2:0]  gp_n;
  logic        emit;
  logic        pop, q_free, move, take;

  assign cfg_ready = 1'b1;

  assign out_valid       = (q_cnt_r != 3'd0);
  assign out_char        = q_r[0].chr;
  assign out_char_valid  = q_r[0].char_valid;
  assign out_bad_hex     = q_r[0].bad_hex;
  assign out_run_last    = q_r[0].run_last;
  assign out_stream_done = q_r[0].stream_done;

  assign pop      = out_valid && !out_stall;
  assign q_free   = (q_cnt_r == 3'd0) || (q_cnt_r == 3'd1 && pop);
  assign move     = in_vld_r && q_free;
  assign in_stall = in_vld_r && !q_free;
  assign take     = in_valid && !in_stall;

  always_comb begin
    for (int i = 0; i < RES_DEPTH; i++) begin
      lst[i] = '0;
    end
    n      = 3'd0;
    hv     = hex_digit_of(chr_r);
    bv     = b64_value(chr_r);
    nb     = buf_r;
    nc     = cnt_r;
    nb2    = buf_r;
    nc2    = cnt_r;
    sx     = '0;
    byte_v = '0;
    emit   = 1'b0;
    gp_n   = gp_r;
    if (!mode_r) begin
      if (!hv[4]) begin
        lst[0].bad_hex = 1'b1;
        n = 3'd1;
      end else begin
        nb   = {buf_r[9:0], hv[3:0]};
        nc   = cnt_r + 4'd4;
        gp_n = (gp_r == GROUP_DIGITS - 3'd1) ? 3'd0 : gp_r + 3'd1;
        emit = (nc >= 4'd6);
        nb2  = nb;
        nc2  = nc;
        if (emit) begin
          sx  = 6'(nb >> (nc - 4'd6));
          nc2 = nc - 4'd6;
          nb2 = nb & ((14'd1 << nc2) - 14'd1);
          lst[0].chr        = b64_char(sx);
          lst[0].char_valid = 1'b1;
          n = 3'd1;
        end
      end
      if (eos_r) begin
        if (nc2 != 4'd0) begin
          lst[n[1:0]].chr        = b64_char(6'(nb2 << (4'd6 - nc2)));
          lst[n[1:0]].char_valid = 1'b1;
          n = n + 3'd1;
        end
        if (gp_n == PAD_TWO_POS) begin
          lst[n[1:0]].chr        = PAD_CHAR;
          lst[n[1:0]].char_valid = 1'b1;
          n = n + 3'd1;
          lst[n[1:0]].chr        = PAD_CHAR;
          lst[n[1:0]].char_valid = 1'b1;
          n = n + 3'd1;
        end else if (gp_n == PAD_ONE_POS) begin
          lst[n[1:0]].chr        = PAD_CHAR;
          lst[n[1:0]].char_valid = 1'b1;
          n = n + 3'd1;
        end
      end
    end else if (bv[6]) begin
      nb   = {buf_r[7:0], bv[5:0]};
      nc   = cnt_r + 4'd6;
      emit = (nc >= 4'd8);
      nb2  = nb;
      nc2  = nc;
      if (emit) begin
        byte_v = 8'(nb >> (nc - 4'd8));
        nc2    = nc - 4'd8;
        nb2    = nb & ((14'd1 << nc2) - 14'd1);
        lst[0].chr        = hex_char(byte_v[7:4]);
        lst[0].char_valid = 1'b1;
        lst[1].chr        = hex_char(byte_v[3:0]);
        lst[1].char_valid = 1'b1;
        n = 3'd2;
      end
    end
    if (eos_r) begin
      if (n == 3'd0) begin
        n = 3'd1;
      end
      lst[2'(n - 3'd1)].stream_done = 1'b1;
    end
    if (n != 3'd0) begin
      lst[2'(n - 3'd1)].run_last = 1'b1;
    end
  end

  always_comb begin
    buf_nxt = buf_r;
    cnt_nxt = cnt_r;
    gp_nxt  = gp_r;
    if (move) begin
      if (eos_r) begin
        buf_nxt = '0;
        cnt_nxt = '0;
        gp_nxt  = '0;
      end else begin
        buf_nxt = nb2;
        cnt_nxt = nc2;
        gp_nxt  = gp_n;
      end
    end
    if (cfg_valid && cfg_ready) begin
      buf_nxt = '0;
      cnt_nxt = '0;
      gp_nxt  = '0;
    end
  end

  always_comb begin
    q_nxt     = q_r;
    q_cnt_nxt = q_cnt_r;
    if (move) begin
      q_nxt     = lst;
      q_cnt_nxt = n;
    end else if (pop) begin
      for (int i = 0; i < RES_DEPTH - 1; i++) begin
        q_nxt[i] = q_r[i + 1];
      end
      q_cnt_nxt = q_cnt_r - 3'd1;
    end
  end

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (take) begin
      in_vld_nxt = 1'b1;
    end else if (move) begin
      in_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= 1'b0;
      buf_r    <= '0;
      cnt_r    <= '0;
      gp_r     <= '0;
      in_vld_r <= 1'b0;
      q_cnt_r  <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        mode_r <= cfg_decode_mode;
      end
      buf_r    <= buf_nxt;
      cnt_r    <= cnt_nxt;
      gp_r     <= gp_nxt;
      in_vld_r <= in_vld_nxt;
      q_cnt_r  <= q_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      chr_r <= in_char;
      eos_r <= in_end_of_stream;
    end
    q_r <= q_nxt;
  end

  a_q_depth: assert property (@(posedge clk) disable iff (!rst_n)
    q_cnt_r <= 3'(RES_DEPTH))
    else $error("result queue holds more beats than its depth");

  a_last_marked: assert property (@(posedge clk) disable iff (!rst_n)
    (q_cnt_r == 3'd1) |-> q_r[0].run_last)
    else $error("final queued beat is not marked as the last of its item");

  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stream_done) |-> out_run_last)
    else $error("stream end shown on a beat that is not the last of its item");

  a_enc_count: assert property (@(posedge clk) disable iff (!rst_n)
    !mode_r |-> (cnt_r == 4'd0 || cnt_r == 4'd2 || cnt_r == 4'd4))
    else $error("encode bit count out of range");

  a_dec_count: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r |-> (cnt_r == 4'd0 || cnt_r == 4'd2 || cnt_r == 4'd4 || cnt_r == 4'd6))
    else $error("decode bit count out of range");

  a_group_pos: assert property (@(posedge clk) disable iff (!rst_n)
    gp_r < GROUP_DIGITS)
    else $error("group position out of range");

endmodule

// ===== tb/hex_base64_codec_unit_tb.sv =====
`timescale 1ns / 1ps

module hex_base64_codec_unit_tb;
  import hb64c_pkg::*;

  localparam int CYCLE_LIMIT   = 200_000;
  localparam int SETTLE_CYCLES = 10;
  localparam int REPORT_LIMIT  = 10;

  localparam logic [7:0] CH_0     = "0";
  localparam logic [7:0] CH_9     = "9";
  localparam logic [7:0] CH_UA    = "A";
  localparam logic [7:0] CH_UF    = "F";
  localparam logic [7:0] CH_UZ    = "Z";
  localparam logic [7:0] CH_LA    = "a";
  localparam logic [7:0] CH_LF    = "f";
  localparam logic [7:0] CH_LZ    = "z";
  localparam logic [7:0] CH_PLUS  = "+";
  localparam logic [7:0] CH_SLASH = "/";

  typedef struct packed {
    logic [7:0] ch;
    logic       eos;
  } beat_t;

  logic       clk;
  logic       rst_n = 1'b0;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic       cfg_decode_mode = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_char = 8'h00;
  logic       in_end_of_stream = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_char;
  logic       out_char_valid;
  logic       out_bad_hex;
  logic       out_run_last;
  logic       out_stream_done;

  hex_base64_codec_unit i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_decode_mode (cfg_decode_mode),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_char         (in_char),
    .in_end_of_stream(in_end_of_stream),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_char        (out_char),
    .out_char_valid  (out_char_valid),
    .out_bad_hex     (out_bad_hex),
    .out_run_last    (out_run_last),
    .out_stream_done (out_stream_done)
  );

  beat_t       char_beats[$];
  res_t        pending_codec_results[$];
  beat_t       next_beat;
  res_t        seen_res;
  res_t        want_res;

  logic        decode_q;
  logic [13:0] bit_buf;
  int          nbits;
  logic [2:0]  group_pos;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int cycle_count = 0;
  int beats_in = 0;
  int results_out = 0;
  int stream_ends = 0;
  int mode_writes = 0;
  int mismatch_count = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic res_t make_res(input logic [7:0] ch, input logic valid, input logic bad);
    res_t r;
    r = '0;
    r.chr = ch;
    r.char_valid = valid;
    r.bad_hex = bad;
    return r;
  endfunction

  function automatic logic [7:0] sextet_char(input logic [5:0] s);
    if (s < 6'd26) begin
      return 8'(CH_UA + s);
    end else if (s < 6'd52) begin
      return 8'(CH_LA + s - 6'd26);
    end else if (s < 6'd62) begin
      return 8'(CH_0 + s - 6'd52);
    end else if (s == 6'd62) begin
      return CH_PLUS;
    end
    return CH_SLASH;
  endfunction

  function automatic logic [7:0] nibble_char(input logic [3:0] v);
    return (v < 4'd10) ? 8'(CH_0 + v) : 8'(CH_LA + v - 4'd10);
  endfunction

  function automatic string res_text(input res_t r);
    return $sformatf("char=%h valid=%b bad_hex=%b run_last=%b stream_done=%b",
                     r.chr, r.char_valid, r.bad_hex, r.run_last, r.stream_done);
  endfunction

  task automatic predict_beat(input logic [7:0] c, input logic eos);
    res_t       res[$];
    res_t       tail;
    int         val;
    int         n;
    logic [7:0] byte_v;
    val = -1;
    if (!decode_q) begin
      if (c >= CH_0 && c <= CH_9) begin
        val = c - CH_0;
      end else if (c >= CH_LA && c <= CH_LF) begin
        val = c - CH_LA + 10;
      end else if (c >= CH_UA && c <= CH_UF) begin
        val = c - CH_UA + 10;
      end
      if (val < 0) begin
        res = {res, make_res(8'h00, 1'b0, 1'b1)};
      end else begin
        bit_buf = {bit_buf[9:0], val[3:0]};
        nbits += 4;
        group_pos = (group_pos == GROUP_DIGITS - 3'd1) ? 3'd0 : group_pos + 3'd1;
        while (nbits >= 6) begin
          res = {res, make_res(sextet_char(6'(bit_buf >> (nbits - 6))), 1'b1, 1'b0)};
          nbits -= 6;
          bit_buf &= (14'd1 << nbits) - 14'd1;
        end
      end
      if (eos) begin
        if (nbits > 0) begin
          res = {res, make_res(sextet_char(6'(bit_buf << (6 - nbits))), 1'b1, 1'b0)};
        end
        if (group_pos == PAD_TWO_POS) begin
          res = {res, make_res(PAD_CHAR, 1'b1, 1'b0)};
          res = {res, make_res(PAD_CHAR, 1'b1, 1'b0)};
        end else if (group_pos == PAD_ONE_POS) begin
          res = {res, make_res(PAD_CHAR, 1'b1, 1'b0)};
        end
      end
    end else begin
      if (c >= CH_UA && c <= CH_UZ) begin
        val = c - CH_UA;
      end else if (c >= CH_LA && c <= CH_LZ) begin
        val = c - CH_LA + 26;
      end else if (c >= CH_0 && c <= CH_9) begin
        val = c - CH_0 + 52;
      end else if (c == CH_PLUS) begin
        val = 62;
      end else if (c == CH_SLASH) begin
        val = 63;
      end
      if (val >= 0) begin
        bit_buf = {bit_buf[7:0], val[5:0]};
        nbits += 6;
        while (nbits >= 8) begin
          byte_v = 8'(bit_buf >> (nbits - 8));
          res = {res, make_res(nibble_char(byte_v[7:4]), 1'b1, 1'b0)};
          res = {res, make_res(nibble_char(byte_v[3:0]), 1'b1, 1'b0)};
          nbits -= 8;
          bit_buf &= (14'd1 << nbits) - 14'd1;
        end
      end
    end
    if (eos && res.size() == 0) begin
      res = {res, make_res(8'h00, 1'b0, 1'b0)};
    end
    n = res.size();
    if (n > 0) begin
      tail = res[n - 1];
      tail.run_last = 1'b1;
      tail.stream_done = eos;
      res[n - 1] = tail;
    end
    if (eos) begin
      bit_buf = '0;
      nbits = 0;
      group_pos = '0;
    end
    foreach (res[i]) begin
      pending_codec_results = {pending_codec_results, res[i]};
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_beat(in_char, in_end_of_stream);
        beats_in++;
        if (in_end_of_stream) begin
          stream_ends++;
        end
      end
      if (!in_valid || !in_stall) begin
        if (char_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_beat = char_beats.pop_front();
          in_valid <= 1'b1;
          in_char <= next_beat.ch;
          in_end_of_stream <= next_beat.eos;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
    if (rst_n && out_valid && !out_stall) begin
      seen_res = {out_char, out_char_valid, out_bad_hex, out_run_last, out_stream_done};
      results_out++;
      if (pending_codec_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) begin
          $display("Unexpected result beat: %s", res_text(seen_res));
        end
      end else begin
        want_res = pending_codec_results.pop_front();
        if (seen_res.chr !== want_res.chr || seen_res.char_valid !== want_res.char_valid ||
            seen_res.bad_hex !== want_res.bad_hex || seen_res.run_last !== want_res.run_last ||
            seen_res.stream_done !== want_res.stream_done) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT) begin
            $display("Mismatch on result beat %0d: expected %s, got %s",
                     results_out, res_text(want_res), res_text(seen_res));
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timed out with %0d result beats still expected.", pending_codec_results.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic write_mode(input logic m);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_decode_mode <= m;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    decode_q = m;
    bit_buf = '0;
    nbits = 0;
    group_pos = '0;
    mode_writes++;
    @(negedge clk);
  endtask

  task automatic add_beat(input logic [7:0] c, input logic eos);
    beat_t b;
    b.ch = c;
    b.eos = eos;
    char_beats = {char_beats, b};
  endtask

  task automatic drain_and_settle();
    do @(negedge clk);
    while (char_beats.size() != 0 || in_valid || pending_codec_results.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic logic [7:0] random_hex_digit();
    logic [3:0] v;
    v = 4'($urandom_range(15));
    if (v < 4'd10) begin
      return 8'(CH_0 + v);
    end
    return $urandom_range(1) ? 8'(CH_LA + v - 4'd10) : 8'(CH_UA + v - 4'd10);
  endfunction

  task automatic run_random_phase(input logic m, input int count);
    int roll;
    write_mode(m);
    repeat (count) begin
      roll = $urandom_range(99);
      if (!m) begin
        add_beat((roll < 10) ? 8'($urandom_range(255)) : random_hex_digit(),
                 $urandom_range(9) == 0);
      end else if (roll < 8) begin
        add_beat(PAD_CHAR, $urandom_range(9) == 0);
      end else begin
        add_beat((roll < 15) ? 8'($urandom_range(255)) : sextet_char(6'($urandom_range(63))),
                 $urandom_range(9) == 0);
      end
    end
    drain_and_settle();
  endtask

  initial begin
    decode_q = 1'b0;
    bit_buf = '0;
    nbits = 0;
    group_pos = '0;
    send_idle_pct = 24;
    recv_stall_pct = 79;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Encode corners: bad digits, both letter cases, group positions zero to four at end of stream.
    write_mode(1'b0);
    add_beat(8'h00, 1'b0);
    add_beat("0", 1'b0);
    add_beat("f", 1'b0);
    add_beat("F", 1'b1);
    add_beat("9", 1'b1);
    add_beat("a", 1'b0);
    add_beat("A", 1'b1);
    add_beat("1", 1'b0);
    add_beat("2", 1'b0);
    add_beat("3", 1'b0);
    add_beat("4", 1'b0);
    add_beat(8'hFF, 1'b1);
    add_beat("g", 1'b1);
    drain_and_settle();

    // Decode corners: alphabet edges, skipped characters, bare end markers, dropped bits.
    write_mode(1'b1);
    add_beat("A", 1'b0);
    add_beat("Z", 1'b0);
    add_beat("a", 1'b0);
    add_beat("z", 1'b0);
    add_beat("0", 1'b0);
    add_beat("9", 1'b0);
    add_beat("+", 1'b0);
    add_beat("/", 1'b0);
    add_beat(PAD_CHAR, 1'b0);
    add_beat(8'hFF, 1'b1);
    add_beat("Q", 1'b1);
    add_beat("B", 1'b0);
    add_beat("C", 1'b1);
    drain_and_settle();

    run_random_phase(1'b0, 31);
    run_random_phase(1'b1, 34);

    send_idle_pct = 79;
    recv_stall_pct = 24;
    run_random_phase(1'b1, 34);
    run_random_phase(1'b0, 31);

    send_idle_pct = 0;
    recv_stall_pct = 0;
    run_random_phase(1'b0, 31);
    run_random_phase(1'b1, 33);

    $display("Run covered %0d input beats over %0d mode writes and %0d stream ends.",
             beats_in, mode_writes, stream_ends);
    $display("Checked %0d result beats against the predicted stream, %0d mismatches.",
             results_out, mismatch_count);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
